### src/mbe_pkg.sv
// Package for the modular binomial engine.
// Holds the modulus, field widths, codes and shared structs; no dependencies.
`default_nettype none
package mbe_pkg;
   localparam int TABLE_DEPTH = 4096;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int VAL_W = 30;
   localparam int STAT_W = 2;
   localparam logic [VAL_W-1:0] PRIME = 30'd998244353;
   localparam logic [VAL_W-1:0] INV_EXP = 30'd998244351;
   localparam int MUL_STEPS = VAL_W;
   localparam int CNT_W = $clog2(MUL_STEPS);

   localparam logic ACT_BUILD = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_BUILT = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

   typedef struct packed {
      logic             start;
      logic [VAL_W-1:0] op_a;
      logic [VAL_W-1:0] op_b;
   } mul_req_type;

   typedef struct packed {
      logic              valid;
      logic [VAL_W-1:0]  value;
      logic [STAT_W-1:0] status;
   } result_type;
endpackage
`default_nettype wire

### src/mbe_modmul.sv
// Bit-serial modular multiplier, one multiplier bit per cycle, modulo PRIME.
// Depends on mbe_pkg.
`default_nettype none
module mbe_modmul (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire mbe_pkg::mul_req_type         mul_req,
   output logic                              mul_done,
   output logic [mbe_pkg::VAL_W-1:0]         mul_result
);
   logic [mbe_pkg::VAL_W-1:0] a_ff, b_ff, acc_ff, acc_in;
   logic [mbe_pkg::CNT_W-1:0] cnt_ff;
   logic                      busy_ff, done_ff;
   logic [mbe_pkg::VAL_W:0]   dbl, red1, sum;

   always_comb begin
      dbl  = {acc_ff, 1'b0};
      red1 = (dbl >= {1'b0, mbe_pkg::PRIME}) ? dbl - {1'b0, mbe_pkg::PRIME} : dbl;
      sum  = red1 + (b_ff[mbe_pkg::VAL_W-1] ? {1'b0, a_ff} : '0);
      acc_in = (sum >= {1'b0, mbe_pkg::PRIME}) ?
               mbe_pkg::VAL_W'(sum - {1'b0, mbe_pkg::PRIME}) : mbe_pkg::VAL_W'(sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.start) begin
            a_ff    <= mul_req.op_a;
            b_ff    <= mul_req.op_b;
            acc_ff  <= '0;
            cnt_ff  <= mbe_pkg::CNT_W'(mbe_pkg::MUL_STEPS - 1);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            acc_ff <= acc_in;
            b_ff   <= {b_ff[mbe_pkg::VAL_W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign mul_done   = done_ff;
   assign mul_result = acc_ff;
endmodule
`default_nettype wire

### src/mbe_ctrl.sv
// Sequencer with the factorial and inverse-factorial memories.
// Depends on mbe_pkg; drives the shared mbe_modmul.
`default_nettype none
module mbe_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          item_valid,
   output logic                               item_ready,
   input  wire logic                          item_action,
   input  wire logic [mbe_pkg::IDX_W-1:0]     item_top,
   input  wire logic [mbe_pkg::IDX_W-1:0]     item_choose,
   input  wire logic [mbe_pkg::IDX_W-1:0]     limit,
   output mbe_pkg::mul_req_type               mul_req,
   input  wire logic                          mul_done,
   input  wire logic [mbe_pkg::VAL_W-1:0]     mul_result,
   output mbe_pkg::result_type                result,
   input  wire logic                          result_ready
);
   typedef enum logic [3:0] {
      S_IDLE, S_FAC_GO, S_FAC_WAIT, S_SQ_GO, S_SQ_WAIT, S_PM_GO, S_PM_WAIT,
      S_WRITE, S_Q_RD, S_Q_RD2, S_M1_GO, S_M1_WAIT, S_M2_GO, S_M2_WAIT, S_RESP
   } state_type;

   state_type state_ff;
   logic [mbe_pkg::VAL_W-1:0]  fac_mem [mbe_pkg::TABLE_DEPTH];
   logic [mbe_pkg::VAL_W-1:0]  inv_mem [mbe_pkg::TABLE_DEPTH];
   logic [mbe_pkg::VAL_W-1:0]  fac_rd_ff, inv_rd_ff, inv1_ff;
   logic [mbe_pkg::IDX_W-1:0]  fac_addr_in, inv_addr_in;
   logic                       wr_en_in;
   logic [mbe_pkg::IDX_W-1:0]  idx_ff, lim_ff, built_ff, top_ff, choose_ff;
   logic                       tables_valid_ff;
   logic [mbe_pkg::VAL_W-1:0]  f_ff, acc_ff;
   logic [mbe_pkg::CNT_W-1:0]  bit_ff;
   logic [mbe_pkg::VAL_W-1:0]  res_value_ff;
   logic [mbe_pkg::STAT_W-1:0] res_status_ff;

   always_comb begin
      fac_addr_in = top_ff;
      inv_addr_in = (state_ff == S_Q_RD2) ? top_ff - choose_ff : choose_ff;
      wr_en_in    = (state_ff == S_WRITE);
   end

   always_ff @(posedge clock) begin
      if (wr_en_in) begin
         fac_mem[idx_ff] <= f_ff;
         inv_mem[idx_ff] <= acc_ff;
      end
      fac_rd_ff <= fac_mem[fac_addr_in];
      inv_rd_ff <= inv_mem[inv_addr_in];
   end

   always_comb begin
      mul_req.start = 1'b0;
      mul_req.op_a  = acc_ff;
      mul_req.op_b  = acc_ff;
      case (state_ff)
         S_FAC_GO: begin
            mul_req.start = 1'b1;
            mul_req.op_a  = f_ff;
            mul_req.op_b  = mbe_pkg::VAL_W'(idx_ff);
         end
         S_SQ_GO: mul_req.start = 1'b1;
         S_PM_GO: begin
            mul_req.start = 1'b1;
            mul_req.op_b  = f_ff;
         end
         S_M1_GO: begin
            mul_req.start = 1'b1;
            mul_req.op_a  = fac_rd_ff;
            mul_req.op_b  = inv_rd_ff;
         end
         S_M2_GO: begin
            mul_req.start = 1'b1;
            mul_req.op_b  = inv1_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         tables_valid_ff <= 1'b0;
         built_ff        <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  top_ff        <= item_top;
                  choose_ff     <= item_choose;
                  res_value_ff  <= '0;
                  res_status_ff <= mbe_pkg::STAT_OK;
                  if (item_action == mbe_pkg::ACT_BUILD) begin
                     lim_ff   <= limit;
                     idx_ff   <= '0;
                     f_ff     <= mbe_pkg::VAL_W'(1);
                     acc_ff   <= mbe_pkg::VAL_W'(1);
                     bit_ff   <= mbe_pkg::CNT_W'(mbe_pkg::VAL_W - 1);
                     state_ff <= S_SQ_GO;
                  end else if (!tables_valid_ff) begin
                     res_status_ff <= mbe_pkg::STAT_NOT_BUILT;
                     state_ff      <= S_RESP;
                  end else if (item_top > built_ff) begin
                     res_status_ff <= mbe_pkg::STAT_RANGE;
                     state_ff      <= S_RESP;
                  end else if (item_choose > item_top) begin
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_Q_RD;
                  end
               end
            end
            S_FAC_GO: state_ff <= S_FAC_WAIT;
            S_FAC_WAIT: begin
               if (mul_done) begin
                  f_ff     <= mul_result;
                  acc_ff   <= mbe_pkg::VAL_W'(1);
                  bit_ff   <= mbe_pkg::CNT_W'(mbe_pkg::VAL_W - 1);
                  state_ff <= S_SQ_GO;
               end
            end
            S_SQ_GO: state_ff <= S_SQ_WAIT;
            S_SQ_WAIT: begin
               if (mul_done) begin
                  acc_ff <= mul_result;
                  if (mbe_pkg::INV_EXP[bit_ff]) begin
                     state_ff <= S_PM_GO;
                  end else if (bit_ff == '0) begin
                     state_ff <= S_WRITE;
                  end else begin
                     bit_ff   <= bit_ff - 1'b1;
                     state_ff <= S_SQ_GO;
                  end
               end
            end
            S_PM_GO: state_ff <= S_PM_WAIT;
            S_PM_WAIT: begin
               if (mul_done) begin
                  acc_ff <= mul_result;
                  if (bit_ff == '0) begin
                     state_ff <= S_WRITE;
                  end else begin
                     bit_ff   <= bit_ff - 1'b1;
                     state_ff <= S_SQ_GO;
                  end
               end
            end
            S_WRITE: begin
               if (idx_ff == lim_ff) begin
                  built_ff        <= lim_ff;
                  tables_valid_ff <= 1'b1;
                  state_ff        <= S_RESP;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_FAC_GO;
               end
            end
            S_Q_RD: state_ff <= S_Q_RD2;
            S_Q_RD2: begin
               inv1_ff  <= inv_rd_ff;
               state_ff <= S_M1_GO;
            end
            S_M1_GO: state_ff <= S_M1_WAIT;
            S_M1_WAIT: begin
               if (mul_done) begin
                  acc_ff   <= mul_result;
                  state_ff <= S_M2_GO;
               end
            end
            S_M2_GO: state_ff <= S_M2_WAIT;
            S_M2_WAIT: begin
               if (mul_done) begin
                  res_value_ff <= mul_result;
                  state_ff     <= S_RESP;
               end
            end
            S_RESP: begin
               if (result_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign item_ready    = (state_ff == S_IDLE);
   assign result.valid  = (state_ff == S_RESP);
   assign result.value  = res_value_ff;
   assign result.status = res_status_ff;
endmodule
`default_nettype wire

### src/modular_binomial_engine.sv
// Modular binomial engine top: limit register, sequencer, multiplier, result register.
// A query runs two serial multiplies; error replies skip them.
// Build: per entry a factorial step (none for entry 0) plus a 58-multiply
// exponentiation, all through the one serial multiplier.
// Next transaction accepted in the cycle after a result enters the output register.
// Synchronous active-high reset clears the limit and marks the tables unbuilt.
`default_nettype none
module modular_binomial_engine (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_action,
   input  wire logic [11:0]                        req_top,
   input  wire logic [11:0]                        req_choose,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [29:0]                             rsp_value,
   output logic [1:0]                              rsp_status,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [11:0]                        csr_data
);
   logic [mbe_pkg::IDX_W-1:0]  limit_ff;
   logic                       rsp_valid_ff;
   logic [mbe_pkg::VAL_W-1:0]  rsp_value_ff;
   logic [mbe_pkg::STAT_W-1:0] rsp_status_ff;
   logic                       slot_free;
   mbe_pkg::mul_req_type       mul_req;
   logic                       mul_done;
   logic [mbe_pkg::VAL_W-1:0]  mul_result;
   mbe_pkg::result_type        result;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   mbe_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (req_valid),
      .item_ready   (req_ready),
      .item_action  (req_action),
      .item_top     (req_top),
      .item_choose  (req_choose),
      .limit        (limit_ff),
      .mul_req      (mul_req),
      .mul_done     (mul_done),
      .mul_result   (mul_result),
      .result       (result),
      .result_ready (slot_free)
   );

   mbe_modmul u_modmul (
      .clock      (clock),
      .reset      (reset),
      .mul_req    (mul_req),
      .mul_done   (mul_done),
      .mul_result (mul_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
         if (slot_free) begin
            rsp_valid_ff <= result.valid;
            if (result.valid) begin
               rsp_value_ff  <= result.value;
               rsp_status_ff <= result.status;
            end
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
endmodule
`default_nettype wire

### src/mbe_checker.sv
// Port-level checker for modular_binomial_engine, attached by bind.
// Depends on mbe_pkg.
`default_nettype none
module mbe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [29:0] rsp_value,
   input wire logic [1:0]  rsp_status
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("rsp transaction dropped or changed while stalled");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= mbe_pkg::STAT_RANGE)
      else $error("undefined status code");
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != mbe_pkg::STAT_OK |-> rsp_value == '0)
      else $error("nonzero value with error status");
   a_value_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_value < mbe_pkg::PRIME)
      else $error("value not reduced modulo prime");
endmodule

bind modular_binomial_engine mbe_checker u_mbe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_value  (rsp_value),
   .rsp_status (rsp_status)
);
`default_nettype wire

### tb/modular_binomial_engine_tb.sv
// Testbench for modular_binomial_engine: directed table, then random build/query phases.
// Checks every response against the table's expected value or a local binomial predictor; depends on mbe_pkg.
`timescale 1ns / 100ps
module modular_binomial_engine_tb;

   localparam int IDLE_LIMIT = 400000;
   localparam int SETTLE = 200;
   localparam int PHASE_ITEMS = 175;
   localparam int PHASES = 10;
   localparam longint unsigned MODULUS = 64'd998244353;

   localparam logic ROW_ITEM = 1'b0;
   localparam logic ROW_CSR = 1'b1;

   localparam int MODE_NONE = 0;
   localparam int MODE_SENDER = 1;
   localparam int MODE_RECEIVER = 2;
   localparam int MODE_BOTH = 3;

   typedef struct packed {
      logic [mbe_pkg::VAL_W-1:0]  value;
      logic [mbe_pkg::STAT_W-1:0] status;
   } binom_result_type;

   typedef struct packed {
      logic                       kind;
      logic                       action;
      logic [11:0]                top;
      logic [11:0]                choose;
      logic                       typed;
      logic [mbe_pkg::VAL_W-1:0]  value;
      logic [mbe_pkg::STAT_W-1:0] status;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_action = 1'b0;
   logic [11:0]       req_top = '0;
   logic [11:0]       req_choose = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [29:0]       rsp_value;
   logic [1:0]        rsp_status;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [11:0]       csr_data = '0;

   logic [mbe_pkg::VAL_W-1:0] fact_tbl [mbe_pkg::TABLE_DEPTH];
   logic [mbe_pkg::VAL_W-1:0] inv_fact_tbl [mbe_pkg::TABLE_DEPTH];
   logic              tbl_built = 1'b0;
   logic [11:0]       built_lim = '0;
   logic [11:0]       limit_reg = '0;

   binom_result_type  pending_q [$];
   int                failures = 0;
   int                idle_mode = MODE_NONE;
   bit                hold_rsp = 1'b0;
   bit                hold_done = 1'b0;
   int                hold_count = 0;
   int                quiet_cycles = 0;
   stim_row_type      rows [24];

   modular_binomial_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_action(req_action),
      .req_top   (req_top),
      .req_choose(req_choose),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (rsp_value),
      .rsp_status(rsp_status),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [mbe_pkg::VAL_W-1:0] mod_mul(logic [mbe_pkg::VAL_W-1:0] a,
                                                         logic [mbe_pkg::VAL_W-1:0] b);
      longint unsigned prod;
      prod = longint'(a) * longint'(b);
      return mbe_pkg::VAL_W'(prod % MODULUS);
   endfunction

   function automatic logic [mbe_pkg::VAL_W-1:0] mod_inverse(logic [mbe_pkg::VAL_W-1:0] x);
      logic [mbe_pkg::VAL_W-1:0] acc;
      logic [mbe_pkg::VAL_W-1:0] base;
      longint unsigned  expo;
      acc = mbe_pkg::VAL_W'(1);
      base = x;
      expo = MODULUS - 2;
      while (expo != 0) begin
         if (expo[0]) acc = mod_mul(acc, base);
         base = mod_mul(base, base);
         expo = expo >> 1;
      end
      return acc;
   endfunction

   function automatic binom_result_type binomial_predict(logic action, logic [11:0] top,
                                                          logic [11:0] choose);
      binom_result_type r;
      r.value = '0;
      r.status = mbe_pkg::STAT_OK;
      if (action == mbe_pkg::ACT_BUILD) begin
         fact_tbl[0] = mbe_pkg::VAL_W'(1);
         for (int i = 1; i <= int'(limit_reg); i++)
            fact_tbl[12'(i)] = mod_mul(fact_tbl[12'(i-1)], mbe_pkg::VAL_W'(i));
         for (int i = 0; i <= int'(limit_reg); i++)
            inv_fact_tbl[12'(i)] = mod_inverse(fact_tbl[12'(i)]);
         built_lim = limit_reg;
         tbl_built = 1'b1;
      end else if (!tbl_built) begin
         r.status = mbe_pkg::STAT_NOT_BUILT;
      end else if (top > built_lim) begin
         r.status = mbe_pkg::STAT_RANGE;
      end else if (choose <= top) begin
         r.value = mod_mul(mod_mul(fact_tbl[top], inv_fact_tbl[choose]),
                           inv_fact_tbl[top - choose]);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      failures++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            report_mismatch("unexpected transaction", 32'(rsp_value), 32'd0);
         end else begin
            binom_result_type want;
            want = pending_q.pop_front();
            if (rsp_value !== want.value)
               report_mismatch("value", 32'(rsp_value), 32'(want.value));
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_rsp && !hold_done) begin
         hold_done = 1'b1;
         hold_count = 400;
         rsp_ready <= 1'b0;
      end else if (hold_count > 0) begin
         hold_count--;
         rsp_ready <= 1'b0;
      end else if (idle_mode == MODE_RECEIVER) begin
         rsp_ready <= ($urandom_range(99) >= 63);
      end else if (idle_mode == MODE_BOTH) begin
         rsp_ready <= ($urandom_range(99) >= 15);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(logic action, logic [11:0] top, logic [11:0] choose,
                            logic typed, binom_result_type typed_res);
      int gap;
      binom_result_type want;
      gap = 0;
      if (idle_mode == MODE_SENDER)
         while ($urandom_range(99) < 63) gap++;
      else if (idle_mode == MODE_BOTH)
         while ($urandom_range(99) < 15) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_top <= top;
      req_choose <= choose;
      do @(posedge clock); while (!req_ready);
      want = binomial_predict(action, top, choose);
      pending_q.insert(pending_q.size(), typed ? typed_res : want);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_limit(logic [11:0] lim);
      drain();
      csr_valid <= 1'b1;
      csr_data <= lim;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_data <= 12'($urandom);
      limit_reg = lim;
   endtask

   initial begin
      int lims [PHASES];
      binom_result_type tr;
      logic [11:0] t;
      logic [11:0] c;
      int hi;
      int pick;

      rows[0]  = '{ROW_ITEM, mbe_pkg::ACT_QUERY, 12'd0, 12'd0, 1'b1, 30'd0,
                   mbe_pkg::STAT_NOT_BUILT};
      rows[1]  = '{ROW_ITEM, mbe_pkg::ACT_QUERY, 12'd4095, 12'd4095, 1'b1, 30'd0,
                   mbe_pkg::STAT_NOT_BUILT};
      rows[2]  = '{ROW_ITEM, mbe_pkg::ACT_BUILD, 12'd4095, 12'd4095, 1'b1, 30'd0,
                   mbe_pkg::STAT_OK};
      rows[3]  = '{ROW_ITEM, mbe_pkg::ACT_QUERY, 12'd0, 12'd0, 1'b1, 30'd1, mbe_pkg::STAT_OK};
      rows[4]  = '{ROW_ITEM, mbe_pkg::ACT_QUERY, 12'd1, 12'd0, 1'b1, 30'd0,
                   mbe_pkg::STAT_RANGE};
      rows[5]  = '{ROW_ITEM, mbe_pkg::ACT_QUERY, 12'd0, 12'd4095, 1'b1, 30'd0,
                   mbe_pkg::STAT_OK};
      rows[6]  = '{ROW_ITEM, mbe_pkg::ACT_QUERY, 12'd4095, 12'd0, 1'b1, 30'd0,
                   mbe_pkg::STAT_RANGE};
      rows[7]  = '{ROW_CSR, mbe_pkg::ACT_BUILD, 12'd12, 12'd0, 1'b0, 30'd0, mbe_pkg::STAT_OK};
      rows[8]  = '{ROW_ITEM, mbe_pkg::ACT_BUILD, 12'd0, 12'd0, 1'b1, 30'd0, mbe_pkg::STAT_OK};
      rows[9]  = '{ROW_ITEM, mbe_pkg::ACT_QUERY, 12'd12, 12'd6, 1'b0, 30'd0, mbe_pkg::STAT_OK};
      rows[10] = '{ROW_ITEM, mbe_pkg::ACT_QUERY, 12'd12, 12'd12, 1'b1, 30'd1,
                   mbe_pkg::STAT_OK};
      rows[11] = '{ROW_ITEM, mbe_pkg::ACT_QUERY, 12'd12, 12'd0, 1'b1, 30'd1, mbe_pkg::STAT_OK};
      rows[12] = '{ROW_ITEM, mbe_pkg::ACT_QUERY, 12'd12, 12'd1, 1'b1, 30'd12,
                   mbe_pkg::STAT_OK};
      rows[13] = '{ROW_ITEM, mbe_pkg::ACT_QUERY, 12'd13, 12'd0, 1'b1, 30'd0,
                   mbe_pkg::STAT_RANGE};
      rows[14] = '{ROW_ITEM, mbe_pkg::ACT_QUERY, 12'd5, 12'd4095, 1'b1, 30'd0,
                   mbe_pkg::STAT_OK};
      rows[15] = '{ROW_ITEM, mbe_pkg::ACT_QUERY, 12'd12, 12'd11, 1'b0, 30'd0,
                   mbe_pkg::STAT_OK};
      rows[16] = '{ROW_CSR, mbe_pkg::ACT_BUILD, 12'd4095, 12'd0, 1'b0, 30'd0,
                   mbe_pkg::STAT_OK};
      rows[17] = '{ROW_ITEM, mbe_pkg::ACT_QUERY, 12'd12, 12'd6, 1'b0, 30'd0, mbe_pkg::STAT_OK};
      rows[18] = '{ROW_ITEM, mbe_pkg::ACT_QUERY, 12'd13, 12'd13, 1'b1, 30'd0,
                   mbe_pkg::STAT_RANGE};
      rows[19] = '{ROW_CSR, mbe_pkg::ACT_BUILD, 12'd1, 12'd0, 1'b0, 30'd0, mbe_pkg::STAT_OK};
      rows[20] = '{ROW_ITEM, mbe_pkg::ACT_BUILD, 12'd2730, 12'd1365, 1'b1, 30'd0,
                   mbe_pkg::STAT_OK};
      rows[21] = '{ROW_ITEM, mbe_pkg::ACT_QUERY, 12'd1, 12'd1, 1'b1, 30'd1, mbe_pkg::STAT_OK};
      rows[22] = '{ROW_ITEM, mbe_pkg::ACT_QUERY, 12'd1, 12'd0, 1'b1, 30'd1, mbe_pkg::STAT_OK};
      rows[23] = '{ROW_ITEM, mbe_pkg::ACT_QUERY, 12'd2, 12'd1, 1'b1, 30'd0,
                   mbe_pkg::STAT_RANGE};
      lims = '{0, 3, 40, 1, 17, 60, 2, 25, 9, 33};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         tr.value = rows[i].value;
         tr.status = rows[i].status;
         if (rows[i].kind == ROW_CSR)
            write_limit(rows[i].top);
         else
            send_item(rows[i].action, rows[i].top, rows[i].choose, rows[i].typed, tr);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         write_limit(12'(lims[ph]));
         idle_mode = ph % 4;
         tr = '0;
         send_item(mbe_pkg::ACT_BUILD, 12'($urandom), 12'($urandom), 1'b0, tr);
         if (ph == 2) hold_rsp = 1'b1;
         hi = (lims[ph] + 2 > 4095) ? 4095 : lims[ph] + 2;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99);
            t = (pick < 80) ? 12'($urandom_range(hi)) : 12'($urandom);
            pick = $urandom_range(99);
            if (pick < 70) c = 12'($urandom_range(int'(t)));
            else if (pick < 85) c = 12'($urandom);
            else c = t + 12'($urandom_range(2));
            if (lims[ph] <= 5 && $urandom_range(99) < 3)
               send_item(mbe_pkg::ACT_BUILD, t, c, 1'b0, tr);
            else
               send_item(mbe_pkg::ACT_QUERY, t, c, 1'b0, tr);
         end
      end

      req_valid <= 1'b0;
      idle_mode = MODE_NONE;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (failures == 0 && pending_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
